@@ src/tke4_pkg.sv @@
package tke4_pkg;

  // fixed frame and result geometry
  localparam int CHANNELS = 4;
  localparam int OUT_W    = 46;

  // configuration register indexes
  typedef enum logic {
    CFG_SPATIAL_MODE   = 1'b0,
    CFG_POWER_EXPONENT = 1'b1
  } cfg_index_t;

  // exponent code that selects squaring
  localparam logic [1:0] POWER_SQUARE = 2'd2;

  // lane multiplier operations
  typedef enum logic [2:0] {
    MUL_SQ_A = 3'd0,
    MUL_SQ_B = 3'd1,
    MUL_SQ_C = 3'd2,
    MUL_BB   = 3'd3,
    MUL_AC   = 3'd4
  } mul_op_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    mul_en;
    mul_op_t op;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;
    logic square;
  } dp_status_t;

endpackage

@@ src/tke4_datapath.sv @@
module tke4_datapath #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  logic                                        cfg_index,
  input  logic [1:0]                                  cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]               samples [tke4_pkg::CHANNELS],
  input  logic                                        record_start,
  input  tke4_pkg::dp_cmd_t                           cmd,
  output tke4_pkg::dp_status_t                        status,
  output logic signed [tke4_pkg::OUT_W-1:0]           energy [tke4_pkg::CHANNELS]
);

  localparam int CH   = tke4_pkg::CHANNELS;
  localparam int PW   = 2 * SAMPLE_BITS;
  localparam int MW   = 2 * PW;
  localparam int EW   = (MW + 1 > tke4_pkg::OUT_W + 1) ? MW + 1 : tke4_pkg::OUT_W + 1;
  localparam logic signed [EW-1:0] SAT_HI =
    {{(EW - tke4_pkg::OUT_W + 1){1'b0}}, {(tke4_pkg::OUT_W - 1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  logic                          spatial_mode_r;
  logic [1:0]                    power_exponent_r;
  logic [1:0]                    frames_held_r, frames_held_nxt;
  logic signed [SAMPLE_BITS-1:0] past_old_r [CH];
  logic signed [SAMPLE_BITS-1:0] past_new_r [CH];
  logic signed [PW-1:0]          pa_r [CH];
  logic signed [PW-1:0]          pb_r [CH];
  logic signed [PW-1:0]          pc_r [CH];
  logic signed [MW-1:0]          pbb_r [CH];
  logic signed [MW-1:0]          pac_r [CH];
  logic signed [tke4_pkg::OUT_W-1:0] energy_r [CH];

  logic signed [PW-1:0]          op_a [CH];
  logic signed [PW-1:0]          op_b [CH];
  logic signed [PW-1:0]          op_c [CH];
  logic signed [PW-1:0]          mul_x [CH];
  logic signed [PW-1:0]          mul_y [CH];
  logic signed [MW-1:0]          prod [CH];
  logic signed [EW-1:0]          diff [CH];
  logic signed [tke4_pkg::OUT_W-1:0] sat [CH];

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spatial_mode_r   <= 1'b0;
      power_exponent_r <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tke4_pkg::CFG_SPATIAL_MODE:   spatial_mode_r   <= cfg_wdata[0];
        tke4_pkg::CFG_POWER_EXPONENT: power_exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // count held frames; a record start counts the current frame as the first
  always_comb begin
    if (record_start) begin
      frames_held_nxt = 2'd1;
    end else if (frames_held_r == 2'd2) begin
      frames_held_nxt = 2'd2;
    end else begin
      frames_held_nxt = frames_held_r + 2'd1;
    end
  end

  assign status.produce = spatial_mode_r || (!record_start && (frames_held_r == 2'd2));
  assign status.square  = (power_exponent_r == tke4_pkg::POWER_SQUARE);

  // pick operand triples for each lane
  always_comb begin
    for (int i = 0; i < CH; i++) begin
      if (spatial_mode_r) begin
        op_a[i] = PW'(samples[i]);
        op_b[i] = PW'(samples[(i + 1) % CH]);
        op_c[i] = PW'(samples[(i + 2) % CH]);
      end else begin
        op_a[i] = PW'(past_old_r[i]);
        op_b[i] = PW'(past_new_r[i]);
        op_c[i] = PW'(samples[i]);
      end
    end
  end

  // advance the delay line on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_held_r <= 2'd0;
      for (int i = 0; i < CH; i++) begin
        past_old_r[i] <= '0;
        past_new_r[i] <= '0;
      end
    end else if (cmd.capture) begin
      frames_held_r <= frames_held_nxt;
      for (int i = 0; i < CH; i++) begin
        past_old_r[i] <= past_new_r[i];
        past_new_r[i] <= samples[i];
      end
    end
  end

  // select lane multiplier operands
  always_comb begin
    for (int i = 0; i < CH; i++) begin
      case (cmd.op)
        tke4_pkg::MUL_SQ_A: begin mul_x[i] = pa_r[i]; mul_y[i] = pa_r[i]; end
        tke4_pkg::MUL_SQ_B: begin mul_x[i] = pb_r[i]; mul_y[i] = pb_r[i]; end
        tke4_pkg::MUL_SQ_C: begin mul_x[i] = pc_r[i]; mul_y[i] = pc_r[i]; end
        tke4_pkg::MUL_BB:   begin mul_x[i] = pb_r[i]; mul_y[i] = pb_r[i]; end
        tke4_pkg::MUL_AC:   begin mul_x[i] = pa_r[i]; mul_y[i] = pc_r[i]; end
        default:            begin mul_x[i] = pa_r[i]; mul_y[i] = pc_r[i]; end
      endcase
      prod[i] = mul_x[i] * mul_y[i];
    end
  end

  // load operands, then hold each product
  always_ff @(posedge clk) begin
    for (int i = 0; i < CH; i++) begin
      if (cmd.capture) begin
        pa_r[i] <= op_a[i];
        pb_r[i] <= op_b[i];
        pc_r[i] <= op_c[i];
      end else if (cmd.mul_en) begin
        case (cmd.op)
          tke4_pkg::MUL_SQ_A: pa_r[i]  <= prod[i][PW-1:0];
          tke4_pkg::MUL_SQ_B: pb_r[i]  <= prod[i][PW-1:0];
          tke4_pkg::MUL_SQ_C: pc_r[i]  <= prod[i][PW-1:0];
          tke4_pkg::MUL_BB:   pbb_r[i] <= prod[i];
          tke4_pkg::MUL_AC:   pac_r[i] <= prod[i];
          default: ;
        endcase
      end
    end
  end

  // subtract and clamp to the result range
  always_comb begin
    for (int i = 0; i < CH; i++) begin
      diff[i] = EW'(pbb_r[i]) - EW'(pac_r[i]);
      if (diff[i] > SAT_HI) begin
        sat[i] = SAT_HI[tke4_pkg::OUT_W-1:0];
      end else if (diff[i] < SAT_LO) begin
        sat[i] = SAT_LO[tke4_pkg::OUT_W-1:0];
      end else begin
        sat[i] = diff[i][tke4_pkg::OUT_W-1:0];
      end
    end
  end

  // hold the result until the next load
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < CH; i++) begin
        energy_r[i] <= sat[i];
      end
    end
  end

  assign energy = energy_r;

endmodule

@@ src/tke4_ctrl.sv @@
module tke4_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tke4_pkg::dp_status_t status,
  output tke4_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_A,
    S_SQ_B,
    S_SQ_C,
    S_MUL_BB,
    S_MUL_AC,
    S_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequence the lane multipliers
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.capture   = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.op        = tke4_pkg::MUL_BB;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (status.produce) begin
            state_nxt = status.square ? S_SQ_A : S_MUL_BB;
          end
        end
      end
      S_SQ_A: begin
        cmd.mul_en = 1'b1;
        cmd.op     = tke4_pkg::MUL_SQ_A;
        state_nxt  = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.mul_en = 1'b1;
        cmd.op     = tke4_pkg::MUL_SQ_B;
        state_nxt  = S_SQ_C;
      end
      S_SQ_C: begin
        cmd.mul_en = 1'b1;
        cmd.op     = tke4_pkg::MUL_SQ_C;
        state_nxt  = S_MUL_BB;
      end
      S_MUL_BB: begin
        cmd.mul_en = 1'b1;
        cmd.op     = tke4_pkg::MUL_BB;
        state_nxt  = S_MUL_AC;
      end
      S_MUL_AC: begin
        cmd.mul_en = 1'b1;
        cmd.op     = tke4_pkg::MUL_AC;
        state_nxt  = S_WB;
      end
      S_WB: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/teager_kaiser_energy_4ch.sv @@
// Sequence: a producing frame is captured; with exponent 2 each operand is first squared
// on the lane multipliers (one squaring pass per operand), then b*b and a*c are formed.
// The result is registered once the output register is free; until then the input stalls,
// as there is one multiplier per lane. A frame that gives no result leaves the block idle.
// Reset (rst_n, synchronous, active low): delay line and fill cleared, temporal mode,
// exponent 1, output empty.
module teager_kaiser_energy_4ch #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [1:0]                          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_ch0_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_ch1_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_ch2_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_ch3_sample,
  input  logic                                in_record_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tke4_pkg::OUT_W-1:0]   out_ch0_energy,
  output logic signed [tke4_pkg::OUT_W-1:0]   out_ch1_energy,
  output logic signed [tke4_pkg::OUT_W-1:0]   out_ch2_energy,
  output logic signed [tke4_pkg::OUT_W-1:0]   out_ch3_energy
);

  logic signed [SAMPLE_BITS-1:0]     samples [tke4_pkg::CHANNELS];
  logic signed [tke4_pkg::OUT_W-1:0] energy  [tke4_pkg::CHANNELS];
  tke4_pkg::dp_cmd_t                 cmd;
  tke4_pkg::dp_status_t              status;

  assign samples[0] = in_ch0_sample;
  assign samples[1] = in_ch1_sample;
  assign samples[2] = in_ch2_sample;
  assign samples[3] = in_ch3_sample;

  tke4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tke4_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .samples      (samples),
    .record_start (in_record_start),
    .cmd          (cmd),
    .status       (status),
    .energy       (energy)
  );

  assign out_ch0_energy = energy[0];
  assign out_ch1_energy = energy[1];
  assign out_ch2_energy = energy[2];
  assign out_ch3_energy = energy[3];

endmodule

@@ bench/tb_teager_kaiser_energy_4ch.sv @@
`timescale 1ns / 100ps

module tb_teager_kaiser_energy_4ch;

  localparam int SAMPLE_BITS     = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PHASES          = 8;
  localparam int DIR_ROWS        = 24;
  localparam int IDLE_TAIL       = 12;
  localparam int RX_LONG_HOLD    = 200;
  localparam int ERR_PRINT_MAX   = 50;

  typedef logic signed [SAMPLE_BITS-1:0]     sample_t;
  typedef sample_t [0:tke4_pkg::CHANNELS-1]  frame_t;
  typedef logic signed [tke4_pkg::OUT_W-1:0] energy_t;
  typedef energy_t [0:tke4_pkg::CHANNELS-1]  energies_t;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_TYPED
  } chk_kind_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] expo;
    logic       start;
    frame_t     ch;
    chk_kind_t  kind;
    energies_t  want;
  } dir_row_t;

  localparam sample_t S_MIN  = sample_t'(-(1 << (SAMPLE_BITS - 1)));
  localparam sample_t S_MAX  = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam energy_t E_2_22 = energy_t'(longint'(1) << 22);
  localparam energy_t E_2_44 = energy_t'(longint'(1) << 44);
  localparam longint  E_HI   = (longint'(1) << (tke4_pkg::OUT_W - 1)) - 1;
  localparam longint  E_LO   = -E_HI - 1;

  // directed frames, register setting carried per row
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // straight out of reset: temporal, exponent 1, nothing held
    '{1'b0, 2'd1, 1'b0, {12'sd0, S_MIN, S_MAX, -12'sd1}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, {S_MAX, S_MAX, S_MIN, 12'sd0}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, {12'sd5, -12'sd7, 12'sd100, S_MIN}, CHK_MODEL, '0},
    // record of zero, full negative, zero
    '{1'b0, 2'd1, 1'b1, '0, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, {S_MIN, S_MIN, S_MIN, S_MIN}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, '0, CHK_TYPED, {E_2_22, E_2_22, E_2_22, E_2_22}},
    // records of one and two frames give nothing
    '{1'b0, 2'd1, 1'b1, {12'sd1, 12'sd2, 12'sd3, 12'sd4}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b1, {-12'sd9, 12'sd8, -12'sd7, 12'sd6}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, {12'sd1365, -12'sd1366, 12'sd682, -12'sd683}, CHK_NONE, '0},
    '{1'b0, 2'd1, 1'b0, {-12'sd1365, 12'sd1366, -12'sd682, 12'sd683}, CHK_MODEL, '0},
    // temporal, squared
    '{1'b0, 2'd2, 1'b1, '0, CHK_NONE, '0},
    '{1'b0, 2'd2, 1'b0, {S_MIN, S_MIN, S_MIN, S_MIN}, CHK_NONE, '0},
    '{1'b0, 2'd2, 1'b0, '0, CHK_TYPED, {E_2_44, E_2_44, E_2_44, E_2_44}},
    '{1'b0, 2'd2, 1'b0, {S_MAX, S_MAX, S_MAX, S_MAX}, CHK_MODEL, '0},
    // spatial, exponent 1
    '{1'b1, 2'd1, 1'b0, {12'sd0, S_MIN, 12'sd0, 12'sd0}, CHK_TYPED,
      {E_2_22, 46'sd0, 46'sd0, 46'sd0}},
    '{1'b1, 2'd1, 1'b1, {S_MIN, S_MIN, S_MIN, S_MIN}, CHK_TYPED, '0},
    '{1'b1, 2'd1, 1'b0, {S_MAX, S_MIN, S_MAX, S_MIN}, CHK_MODEL, '0},
    // spatial, squared: largest and smallest reachable results
    '{1'b1, 2'd2, 1'b0, {S_MIN, 12'sd0, S_MIN, 12'sd0}, CHK_TYPED,
      {-E_2_44, E_2_44, -E_2_44, E_2_44}},
    '{1'b1, 2'd2, 1'b0, {12'sd0, S_MIN, 12'sd0, 12'sd0}, CHK_TYPED,
      {E_2_44, 46'sd0, 46'sd0, 46'sd0}},
    '{1'b1, 2'd2, 1'b0, {12'sd123, -12'sd456, 12'sd789, -12'sd1011}, CHK_MODEL, '0},
    // mode change inside a record: the two spatial frames are still held
    '{1'b0, 2'd1, 1'b0, {12'sd1, 12'sd1, 12'sd1, 12'sd1}, CHK_MODEL, '0},
    // exponent codes 0 and 3 behave as 1
    '{1'b0, 2'd0, 1'b0, {12'sd3, -12'sd3, 12'sd7, -12'sd7}, CHK_MODEL, '0},
    '{1'b1, 2'd3, 1'b0, {S_MIN, S_MAX, -12'sd1, 12'sd1}, CHK_MODEL, '0},
    '{1'b1, 2'd0, 1'b0, {S_MAX, S_MAX, S_MAX, S_MAX}, CHK_TYPED, '0}
  };

  // register settings for the random phases
  localparam logic       PHASE_MODE [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1,
                                                 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [1:0] PHASE_EXPO [PHASES] = '{2'd2, 2'd2, 2'd1, 2'd1,
                                                 2'd3, 2'd0, 2'd2, 2'd2};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [1:0]          cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  sample_t             in_ch0_sample;
  sample_t             in_ch1_sample;
  sample_t             in_ch2_sample;
  sample_t             in_ch3_sample;
  logic                in_record_start;
  logic                out_valid;
  logic                out_stall;
  energy_t             out_ch0_energy;
  energy_t             out_ch1_energy;
  energy_t             out_ch2_energy;
  energy_t             out_ch3_energy;

  // predictor state and register copies
  logic                model_spatial;
  logic [1:0]          model_expo;
  frame_t              older_frame;
  frame_t              newer_frame;
  int unsigned         frames_kept;

  energies_t           pending_energies [$];
  int                  errors;
  int                  frames_sent;
  int                  results_checked;
  int                  settings_used;
  int                  hold_requests;
  logic                tx_quiet;
  logic                rx_quiet;

  teager_kaiser_energy_4ch #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch0_sample   (in_ch0_sample),
    .in_ch1_sample   (in_ch1_sample),
    .in_ch2_sample   (in_ch2_sample),
    .in_ch3_sample   (in_ch3_sample),
    .in_record_start (in_record_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ch0_energy  (out_ch0_energy),
    .out_ch1_energy  (out_ch1_energy),
    .out_ch2_energy  (out_ch2_energy),
    .out_ch3_energy  (out_ch3_energy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #5ms;
    $display("Run timed out with %0d results outstanding", pending_energies.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= ERR_PRINT_MAX) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // append one expected result behind those already waiting
  task automatic queue_expected(input energies_t e);
    pending_energies.insert(pending_energies.size(), e);
  endtask

  // b*b - a*c on samples, each squared first when the exponent code selects squaring, saturated to the output width
  function automatic energy_t teager_energy(sample_t a, sample_t b, sample_t c);
    longint pa, pb, pc, e;
    pa = a;
    pb = b;
    pc = c;
    if (model_expo == tke4_pkg::POWER_SQUARE) begin
      pa = pa * pa;
      pb = pb * pb;
      pc = pc * pc;
    end
    e = pb * pb - pa * pc;
    if (e > E_HI) e = E_HI;
    if (e < E_LO) e = E_LO;
    return energy_t'(e);
  endfunction

  // advance the predictor by one frame
  task automatic predict_frame(input frame_t smp, input logic start,
                               output logic produced, output energies_t result);
    int c;
    produced = 1'b0;
    result   = '0;
    if (start) frames_kept = 0;
    if (model_spatial) begin
      for (c = 0; c < tke4_pkg::CHANNELS; c++)
        result[c] = teager_energy(smp[c], smp[(c + 1) % tke4_pkg::CHANNELS],
                                  smp[(c + 2) % tke4_pkg::CHANNELS]);
      produced = 1'b1;
    end else if (frames_kept == 2) begin
      for (c = 0; c < tke4_pkg::CHANNELS; c++)
        result[c] = teager_energy(older_frame[c], newer_frame[c], smp[c]);
      produced = 1'b1;
    end
    older_frame = newer_frame;
    newer_frame = smp;
    if (frames_kept < 2) frames_kept++;
  endtask

  // offer one frame, hold it until the transfer, then record what it should give
  task automatic offer_frame(input frame_t smp, input logic start,
                             input chk_kind_t kind, input energies_t want);
    int        gap;
    logic      produced;
    energies_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_ch0_sample   <= smp[0];
    in_ch1_sample   <= smp[1];
    in_ch2_sample   <= smp[2];
    in_ch3_sample   <= smp[3];
    in_record_start <= start;
    do @(posedge clk); while (in_stall);
    predict_frame(smp, start, produced, predicted);
    frames_sent++;
    if (kind == CHK_TYPED) queue_expected(want);
    else if (kind == CHK_MODEL && produced) queue_expected(predicted);
    @(negedge clk);
  endtask

  // drop valid and let every outstanding result drain, plus the pipeline tail
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_energies.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic write_reg(input tke4_pkg::cfg_index_t idx, input logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      tke4_pkg::CFG_SPATIAL_MODE:   model_spatial = value[0];
      tke4_pkg::CFG_POWER_EXPONENT: model_expo    = value;
      default: ;
    endcase
  endtask

  // result side: short stalls after each transfer, long hold on request
  initial begin
    int   gap_left;
    int   hold_left;
    int   holds_served;
    logic took;
    gap_left     = 0;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      took = rst_n && out_valid && !out_stall;
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = RX_LONG_HOLD;
      end
      if (took) gap_left = rx_quiet ? 0 : $urandom_range(0, 5);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transfer with the oldest prediction
  initial begin
    energies_t seen;
    energies_t want;
    int        c;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen = {out_ch0_energy, out_ch1_energy, out_ch2_energy, out_ch3_energy};
        if (pending_energies.size() == 0) begin
          flag_error("result transfer with no prediction outstanding");
        end else begin
          want = pending_energies.pop_front();
          for (c = 0; c < tke4_pkg::CHANNELS; c++)
            if (seen[c] !== want[c])
              flag_error($sformatf("ch%0d energy %0d, predicted %0d", c, seen[c], want[c]));
          results_checked++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int     r;
    int     ph;
    int     n;
    int     k;
    int     c;
    int     rec_len;
    int     directed_frames;
    logic   start;
    frame_t smp;

    errors          = 0;
    frames_sent     = 0;
    results_checked = 0;
    settings_used   = 1;
    hold_requests   = 0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    model_spatial   = 1'b0;
    model_expo      = 2'd1;
    older_frame     = '0;
    newer_frame     = '0;
    frames_kept     = 0;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = tke4_pkg::CFG_SPATIAL_MODE;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_ch0_sample   = '0;
    in_ch1_sample   = '0;
    in_ch2_sample   = '0;
    in_ch3_sample   = '0;
    in_record_start = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, writing registers only once the block has drained
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].mode != model_spatial || DIR_TABLE[r].expo != model_expo) begin
        wait_idle();
        write_reg(tke4_pkg::CFG_SPATIAL_MODE, {1'b0, DIR_TABLE[r].mode});
        write_reg(tke4_pkg::CFG_POWER_EXPONENT, DIR_TABLE[r].expo);
        settings_used++;
      end
      offer_frame(DIR_TABLE[r].ch, DIR_TABLE[r].start, DIR_TABLE[r].kind, DIR_TABLE[r].want);
    end
    directed_frames = frames_sent;

    // random phases: mostly well-formed records, some short or broken ones
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(tke4_pkg::CFG_SPATIAL_MODE, {1'($urandom_range(0, 1)), PHASE_MODE[ph]});
      write_reg(tke4_pkg::CFG_POWER_EXPONENT, PHASE_EXPO[ph]);
      settings_used++;
      tx_quiet = (ph == 1) || (ph == 3);
      rx_quiet = (ph == 3);
      // back up the block: receiver holds off while frames keep coming
      if (ph == 1) hold_requests++;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        rec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
        for (k = 0; k < rec_len && n < ITEMS_PER_PHASE; k++) begin
          start = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
          for (c = 0; c < tke4_pkg::CHANNELS; c++)
            case ($urandom_range(0, 7))
              0:       smp[c] = S_MIN;
              1:       smp[c] = S_MAX;
              2:       smp[c] = '0;
              default: smp[c] = sample_t'($urandom);
            endcase
          offer_frame(smp, start, CHK_MODEL, '0);
          n++;
          if ($urandom_range(0, 39) == 0) wait_idle();
        end
      end
    end

    wait_idle();
    $display("Sent %0d frames (%0d directed) across %0d register settings, both modes,",
             frames_sent, directed_frames, settings_used);
    $display("exponent codes 0 to 3 and a long output hold; %0d results checked, %0d errors.",
             results_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
